[src/werm_pkg.sv]
// ----------------------------------------------------------------------------
// werm_pkg
// Shared constants, request codes and divider interface types for the
// windowed event rate meter.
// ----------------------------------------------------------------------------
`default_nettype none

package werm_pkg;

	// Ring geometry
	localparam int WINDOW_DEPTH = 256;
	localparam int ADDR_W       = $clog2(WINDOW_DEPTH);
	localparam int FILL_W       = ADDR_W + 1;

	// Field widths
	localparam int TS_W   = 63;
	localparam int INT_W  = 32;
	localparam int RATE_W = 48;
	localparam int ENT_W  = 9;

	// Event count in a rate is at most WINDOW_DEPTH-1
	localparam int CNT_W = ADDR_W;

	// One second in Q16 microseconds: 1e6 * 65536
	localparam int               USQ_W   = 36;
	localparam logic [USQ_W-1:0] US_Q16  = 36'd65536000000;

	// Dividend = count * US_Q16, quotient never wider than this
	localparam int DVD_W  = CNT_W + USQ_W;
	localparam int STEP_W = $clog2(DVD_W);

	// Request codes
	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_WIN   = 2'd1;
	localparam logic [1:0] ACT_IVL   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	// Divider start request
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [TS_W-1:0]  divisor;
	} div_req_t;

	// Divider response
	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

[src/werm_div.sv]
// ----------------------------------------------------------------------------
// werm_div
// Restoring radix-2 divider, one quotient bit per cycle. Divisor must be
// nonzero; done pulses in the cycle after the last step, with the quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module werm_div
	import werm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [TS_W-1:0]   rem_q;
	logic [TS_W-1:0]   dsr_q;
	logic [DVD_W-1:0]  quo_q;

	logic [TS_W:0]     rem_sh;
	logic [TS_W+1:0]   diff;
	logic              fits;

	// Trial subtract of the shifted partial remainder
	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
	assign fits   = !diff[TS_W+1];

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dsr_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TS_W-1:0] : rem_sh[TS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

[src/windowed_event_rate_meter_unit.sv]
// ----------------------------------------------------------------------------
// windowed_event_rate_meter_unit
// Timestamp ring in a 256-entry synchronous RAM with window and interval
// rate queries in Q16 events per second.
// ----------------------------------------------------------------------------
// Add and clear leave the sequencer idle, so in_ready stays high.
// Window query: 2 RAM reads, multiply, 44-step divide.
// Interval query: the backward walk reads one RAM entry per cycle (up to
// 256) and then runs the 44-step divider.
// One request is in flight at a time; a result waits in the output register.
// Reset empties the ring (slot and fill count); RAM contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_event_rate_meter_unit
	import werm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [TS_W-1:0]   timestamp_us,
	input  wire logic [INT_W-1:0]  interval_us,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [RATE_W-1:0]      rate_q16,
	output logic [ENT_W-1:0]       entries_used
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_NEW  = 3'd1;
	localparam logic [2:0] S_OLD  = 3'd2;
	localparam logic [2:0] S_WALK = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] write_slot_q;
	logic [FILL_W-1:0] fill_q;
	logic              ivl_q;
	logic [INT_W-1:0]  interval_q;
	logic [TS_W-1:0]   newest_q;
	logic [TS_W-1:0]   limit_q;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  count_q;
	logic [TS_W-1:0]   dsr_q;
	logic [DVD_W-1:0]  res_rate_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              out_valid_q;
	logic [RATE_W-1:0] rate_q;
	logic [ENT_W-1:0]  entries_q;

	// Timestamp ring
	logic [TS_W-1:0]   ring [WINDOW_DEPTH];
	logic [TS_W-1:0]   rd_data_q;
	logic [ADDR_W-1:0] rd_addr;
	logic              wr_en;

	logic              accept;
	logic [TS_W:0]     span;
	logic              span_neg;
	logic              span_pos;
	logic              span_short;
	logic [CNT_W-1:0]  win_cnt;
	logic [FILL_W-1:0] fill_m1;
	logic              hit;
	logic              out_free;

	div_req_t          div_req;
	div_rsp_t          div_rsp;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign wr_en    = accept && (action == ACT_ADD);
	assign out_free = !out_valid_q || out_ready;

	// Span between newest and oldest, sign in the top bit
	assign span       = {1'b0, newest_q} - {1'b0, rd_data_q};
	assign span_neg   = span[TS_W];
	assign span_pos   = !span_neg && (span != '0);
	assign span_short = !span_neg && (span < {{(TS_W + 1 - INT_W){1'b0}}, interval_q});
	assign fill_m1    = fill_q - FILL_W'(1);
	assign win_cnt    = fill_m1[CNT_W-1:0];

	// Walk: first entry at or before the limit
	assign hit = (rd_data_q <= limit_q);

	// Read address per state; a read never hits the entry written in that cycle
	always_comb begin
		unique case (state_q)
			S_IDLE:  rd_addr = write_slot_q - ADDR_W'(1);
			S_NEW:   rd_addr = write_slot_q - fill_q[ADDR_W-1:0];
			S_OLD:   rd_addr = write_slot_q - ADDR_W'(1);
			default: rd_addr = addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring[write_slot_q] <= timestamp_us;
		end
		rd_data_q <= ring[rd_addr];
	end

	// Divider request: product is registered inside the divider
	assign div_req.start    = (state_q == S_MUL);
	assign div_req.dividend = {{USQ_W{1'b0}}, count_q} * {{CNT_W{1'b0}}, US_Q16};
	assign div_req.divisor  = dsr_q;

	werm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			write_slot_q <= '0;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_ADD: begin
								write_slot_q <= write_slot_q + ADDR_W'(1);
								if (fill_q != FILL_W'(WINDOW_DEPTH)) begin
									fill_q <= fill_q + FILL_W'(1);
								end
							end
							ACT_CLEAR: begin
								write_slot_q <= '0;
								fill_q       <= '0;
							end
							default: begin
								if (fill_q == '0 ||
								    (action == ACT_IVL && interval_us == '0)) begin
									state_q <= S_OUT;
								end else begin
									state_q <= S_NEW;
								end
							end
						endcase
					end
				end
				S_NEW: state_q <= S_OLD;
				S_OLD: begin
					if (!ivl_q || span_short) begin
						state_q <= (win_cnt != '0 && span_pos) ? S_MUL : S_OUT;
					end else if (span_neg) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (hit) begin
						state_q <= (cnt_q != '0) ? S_MUL : S_OUT;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Query datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				ivl_q      <= (action == ACT_IVL);
				interval_q <= interval_us;
				res_rate_q <= '0;
				res_cnt_q  <= '0;
			end
			S_NEW: newest_q <= rd_data_q;
			S_OLD: begin
				count_q <= win_cnt;
				dsr_q   <= span[TS_W-1:0];
				limit_q <= newest_q - {{(TS_W - INT_W){1'b0}}, interval_q};
				addr_q  <= write_slot_q - ADDR_W'(2);
				cnt_q   <= '0;
			end
			S_WALK: begin
				addr_q  <= addr_q - ADDR_W'(1);
				cnt_q   <= cnt_q + CNT_W'(1);
				count_q <= cnt_q;
				dsr_q   <= newest_q - rd_data_q;
			end
			S_DIV: begin
				if (div_rsp.done) begin
					res_rate_q <= div_rsp.quotient;
					res_cnt_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register; quotient stays below 2^44 so no saturation is reached
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			rate_q    <= RATE_W'(res_rate_q);
			entries_q <= ENT_W'(res_cnt_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign rate_q16     = rate_q;
	assign entries_used = entries_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("fill count above ring depth");

	a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != FILL_W'(WINDOW_DEPTH)) |-> (write_slot_q == fill_q[ADDR_W-1:0]))
		else $error("write slot out of step with fill count");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && fill_q != FILL_W'(WINDOW_DEPTH)) |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("add did not grow the ring");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider finished outside divide state");

	a_zero_count_zero_rate: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && entries_q == '0) |-> (rate_q == '0))
		else $error("nonzero rate with no events");

endmodule

`default_nettype wire

[dv/werm_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// werm_checker
// Watches both channels of the windowed event rate meter. A mirror of the
// timestamp ring predicts each query result, and every returned result is
// compared field by field, in order, with the oldest prediction.
// ----------------------------------------------------------------------------

module werm_checker
	import werm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_ready,
	input  wire logic [1:0]        action,
	input  wire logic [TS_W-1:0]   timestamp_us,
	input  wire logic [INT_W-1:0]  interval_us,
	input  wire logic              out_valid,
	input  wire logic              out_ready,
	input  wire logic [RATE_W-1:0] rate_q16,
	input  wire logic [ENT_W-1:0]  entries_used,
	output int                     fail_count,
	output int                     pending,
	output int                     checked
);

	typedef struct packed {
		logic [RATE_W-1:0] rate;
		logic [ENT_W-1:0]  entries;
	} rate_result_t;

	localparam longint unsigned Q16_SECOND = 64'(US_Q16);
	localparam longint unsigned RATE_CAP   = {RATE_W{1'b1}};

	// Mirror of the ring; only written slots are ever read
	logic [TS_W-1:0] stamp_mirror [WINDOW_DEPTH];
	int unsigned     next_slot   = 0;
	int unsigned     stamps_held = 0;

	rate_result_t rate_expect_q[$];
	int           mismatches = 0;
	int           n_checked  = 0;

	initial begin
		fail_count = 0;
		pending    = 0;
		checked    = 0;
	end

	// Timestamp by age, 0 being the oldest held entry
	function automatic longint stamp_by_age(input int unsigned pos);
		int unsigned idx;
		idx = (next_slot + WINDOW_DEPTH - stamps_held + pos) % WINDOW_DEPTH;
		return longint'({1'b0, stamp_mirror[idx]});
	endfunction

	// Q16 events per second for a count over a span in microseconds
	function automatic rate_result_t rate_of(input longint unsigned events,
		input longint span);
		rate_result_t    res;
		longint unsigned q;
		res = '0;
		if (events == 0 || span <= 0)
			return res;
		q = (events * Q16_SECOND) / $unsigned(span);
		if (q > RATE_CAP)
			q = RATE_CAP;
		res.rate    = q[RATE_W-1:0];
		res.entries = events[ENT_W-1:0];
		return res;
	endfunction

	function automatic rate_result_t window_rate();
		if (stamps_held == 0)
			return '0;
		return rate_of(stamps_held - 1, stamp_by_age(stamps_held - 1) - stamp_by_age(0));
	endfunction

	// Count entries newer than the newest one at or before newest - look_back
	function automatic rate_result_t interval_rate(input longint unsigned look_back);
		longint newest;
		longint span;
		longint limit;
		longint v;
		int     pos;
		if (stamps_held == 0 || look_back == 0)
			return '0;
		newest = stamp_by_age(stamps_held - 1);
		span   = newest - stamp_by_age(0);
		if (span < 0)
			return '0;
		if ($unsigned(span) < look_back)
			return window_rate();
		limit = newest - longint'(look_back);
		for (pos = int'(stamps_held) - 1; pos >= 0; pos--) begin
			v = stamp_by_age(pos);
			if (v <= limit)
				return rate_of(stamps_held - 1 - pos, newest - v);
		end
		return '0;
	endfunction

	task automatic note(input string msg);
		if (mismatches < 10)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	// Compare returned results, then fold accepted requests into the mirror
	always @(posedge clk or negedge arst_n) begin : watch
		rate_result_t want;
		if (!arst_n) begin
			next_slot   = 0;
			stamps_held = 0;
			rate_expect_q.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (rate_expect_q.size() == 0) begin
					note($sformatf("result with no query pending: rate_q16 %0d entries %0d",
						rate_q16, entries_used));
				end else begin
					want = rate_expect_q.pop_front();
					n_checked++;
					if (rate_q16 !== want.rate)
						note($sformatf("rate_q16 expected %0d, got %0d", want.rate, rate_q16));
					if (entries_used !== want.entries)
						note($sformatf("entries_used expected %0d, got %0d",
							want.entries, entries_used));
				end
			end
			if (in_valid && in_ready) begin
				case (action)
					ACT_ADD: begin
						stamp_mirror[next_slot] = timestamp_us;
						next_slot = (next_slot + 1) % WINDOW_DEPTH;
						if (stamps_held < WINDOW_DEPTH)
							stamps_held++;
					end
					ACT_WIN: rate_expect_q.push_back(window_rate());
					ACT_IVL: rate_expect_q.push_back(interval_rate(interval_us));
					default: begin
						next_slot   = 0;
						stamps_held = 0;
					end
				endcase
			end
		end
		fail_count <= mismatches;
		pending    <= rate_expect_q.size();
		checked    <= n_checked;
	end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the windowed event rate meter with a directed opening and then runs
// of rising timestamps with interleaved window and interval queries, noise
// and clears, under bursty requests and a stalling result sink.
// ----------------------------------------------------------------------------

module tb
	import werm_pkg::*;
();

	localparam int              REQ_TARGET = 1550;
	localparam logic [TS_W-1:0] TS_ALT     = 63'h2AAA_AAAA_AAAA_AAAA;

	typedef enum logic [1:0] {SINK_OPEN, SINK_RANDOM, SINK_RUNS} sink_mode_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              in_valid     = 1'b0;
	logic              in_ready;
	logic [1:0]        action       = ACT_ADD;
	logic [TS_W-1:0]   timestamp_us = '0;
	logic [INT_W-1:0]  interval_us  = '0;
	logic              out_valid;
	logic              out_ready    = 1'b0;
	logic [RATE_W-1:0] rate_q16;
	logic [ENT_W-1:0]  entries_used;

	int fail_count;
	int pending;
	int checked;

	// Sender bookkeeping: recent stamps steer interval choice
	logic [TS_W-1:0] stamp_hist[$];
	int burst_left  = 0;
	int n_req       = 0;
	int n_add       = 0;
	int n_win       = 0;
	int n_ivl       = 0;
	int n_clear     = 0;
	int n_overwrite = 0;

	sink_mode_t sink_mode = SINK_OPEN;
	int         sink_left = 0;
	int         sink_run  = 0;

	windowed_event_rate_meter_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.timestamp_us (timestamp_us),
		.interval_us  (interval_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rate_q16     (rate_q16),
		.entries_used (entries_used)
	);

	werm_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.timestamp_us (timestamp_us),
		.interval_us  (interval_us),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rate_q16     (rate_q16),
		.entries_used (entries_used),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Result sink: always open, random stalls, or long on/off runs
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode <= sink_mode_t'($urandom_range(0, 2));
			sink_left <= $urandom_range(50, 400);
		end else begin
			sink_left <= sink_left - 1;
		end
		case (sink_mode)
			SINK_OPEN:   out_ready <= 1'b1;
			SINK_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
			default: begin
				if (sink_run == 0) begin
					out_ready <= ~out_ready;
					sink_run  <= $urandom_range(1, 25);
				end else begin
					sink_run <= sink_run - 1;
				end
			end
		endcase
	end

	function automatic logic [TS_W-1:0] rand_ts();
		return TS_W'({$urandom, $urandom});
	endfunction

	// Look-back interval, mostly tied to the span the ring holds now
	function automatic logic [INT_W-1:0] pick_interval();
		logic [TS_W-1:0] span;
		span = (stamp_hist.size() > 1) ? stamp_hist[$] - stamp_hist[0] : '0;
		case ($urandom_range(0, 11))
			0: return '0;
			1: return $urandom;
			2: return $urandom_range(1, 1000);
			default: begin
				if (span == 0 || span > 63'hFFFF_FFFE)
					return $urandom;
				case ($urandom_range(0, 3))
					0:       return INT_W'(span);
					1:       return INT_W'(span + 1);
					default: return $urandom_range(1, 32'(span));
				endcase
			end
		endcase
	endfunction

	// One request; gaps open between bursts, valid holds until accepted
	task automatic send_req(input logic [1:0] act, input logic [TS_W-1:0] ts,
		input logic [INT_W-1:0] ivl);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 60 : 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
			                                         : $urandom_range(1, 20);
		end
		burst_left--;
		in_valid     <= 1'b1;
		action       <= act;
		timestamp_us <= ts;
		interval_us  <= ivl;
		do @(posedge clk); while (!in_ready);
		n_req++;
		case (act)
			ACT_ADD: begin
				if (stamp_hist.size() == WINDOW_DEPTH) begin
					void'(stamp_hist.pop_front());
					n_overwrite++;
				end
				stamp_hist.push_back(ts);
				n_add++;
			end
			ACT_WIN: n_win++;
			ACT_IVL: n_ivl++;
			default: begin
				stamp_hist.delete();
				n_clear++;
			end
		endcase
	endtask

	// Hold off requests until every query has been answered
	task automatic drain_results();
		in_valid   <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [TS_W-1:0] ts;
		int unsigned     step_cap;
		int              n_adds;
		int              r;
		int              seq_no;
		int              random_start;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty ring, single entry, zero span, interval edges,
		// huge span, clear, backwards timestamps
		send_req(ACT_WIN, {TS_W{1'b1}}, {INT_W{1'b1}});
		send_req(ACT_IVL, '0, {INT_W{1'b1}});
		send_req(ACT_ADD, '0, '0);
		send_req(ACT_WIN, '0, '0);
		send_req(ACT_IVL, '0, 32'd1);
		send_req(ACT_ADD, '0, {INT_W{1'b1}});
		send_req(ACT_WIN, '0, '0);
		send_req(ACT_IVL, '0, 32'd5);
		send_req(ACT_ADD, 63'd1000, '0);
		send_req(ACT_WIN, '0, '0);
		send_req(ACT_IVL, '0, '0);
		send_req(ACT_IVL, '0, 32'd1);
		send_req(ACT_IVL, '0, 32'd1000);
		send_req(ACT_IVL, '0, {INT_W{1'b1}});
		send_req(ACT_ADD, {TS_W{1'b1}}, '0);
		send_req(ACT_WIN, '0, '0);
		send_req(ACT_IVL, '0, {INT_W{1'b1}});
		send_req(ACT_CLEAR, '0, '0);
		send_req(ACT_WIN, '0, '0);
		send_req(ACT_ADD, ~TS_ALT, 32'h5555_5555);
		send_req(ACT_ADD, TS_ALT, 32'hAAAA_AAAA);
		send_req(ACT_WIN, TS_ALT, '0);
		send_req(ACT_IVL, ~TS_ALT, 32'hAAAA_AAAA);
		send_req(ACT_CLEAR, TS_ALT, 32'h5555_5555);

		// Random runs of rising stamps with queries and some noise
		random_start = n_req;
		seq_no = 0;
		while (n_req - random_start < REQ_TARGET) begin
			if ($urandom_range(0, 3) == 0)
				send_req(ACT_CLEAR, rand_ts(), $urandom);
			if (seq_no == 6 || $urandom_range(0, 9) == 0)
				drain_results();
			case ($urandom_range(0, 3))
				0:       ts = '0;
				1:       ts = $urandom_range(0, 1000);
				2:       ts = rand_ts();
				default: ts = {TS_W{1'b1}} - $urandom_range(0, 100000);
			endcase
			case ($urandom_range(0, 4))
				0:       step_cap = 1;
				1:       step_cap = 16;
				2:       step_cap = 1000;
				3:       step_cap = 1000000;
				default: step_cap = 32'hFFFF_FFFF;
			endcase
			n_adds = ($urandom_range(0, 9) == 0) ? $urandom_range(257, 300)
			                                     : $urandom_range(2, 40);
			repeat (n_adds) begin
				ts = ts + $urandom_range(0, step_cap);
				send_req(ACT_ADD, ts, $urandom);
				r = $urandom_range(0, 19);
				if (r < 4)
					send_req(ACT_IVL, rand_ts(), pick_interval());
				else if (r < 7)
					send_req(ACT_WIN, rand_ts(), $urandom);
				else if (r == 7)
					send_req(2'($urandom_range(0, 3)), rand_ts(), $urandom);
			end
			send_req(ACT_WIN, rand_ts(), $urandom);
			send_req(ACT_IVL, rand_ts(), pick_interval());
			seq_no++;
		end

		drain_results();
		repeat (400) @(posedge clk);

		$display("Sent %0d requests: %0d adds (%0d overwrote a full ring), %0d clears",
			n_req, n_add, n_overwrite, n_clear);
		$display("Answered %0d window and %0d interval queries, %0d results compared",
			n_win, n_ivl, checked);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog for a hung handshake or a missing result
	initial begin
		#40_000_000;
		$display("Timeout with %0d results outstanding", pending);
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
src/werm_pkg.sv
src/werm_div.sv
src/windowed_event_rate_meter_unit.sv
dv/werm_checker.sv
dv/tb.sv
